// File: rtl/assert_macros.svh
// shared assertion macros for the normalizer checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define DTN_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtn check failed");

// next-cycle implication, disabled while reset is held
`define DTN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtn check failed");

`endif

// File: rtl/dtn_pkg.sv
`timescale 1ns / 1ps

package dtn_pkg;

    // field widths
    localparam int YR_IN_W  = 14;
    localparam int MON_IN_W = 8;
    localparam int FLD_IN_W = 16;
    localparam int YR_OUT_W = 15;
    localparam int MON_W    = 4;
    localparam int DAY_W    = 5;
    localparam int HR_W     = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;

    // internal widths
    localparam int VAL_W = 17;   // working second/minute/hour/day values
    localparam int YR_W  = 16;   // working year
    localparam int DIV_W = 18;   // biased dividend and quotient
    localparam int REM_W = 9;    // remainder, below 400
    localparam int SUM_W = 19;   // dividend bias sum
    localparam int CYC_W = 9;    // position in the 400 year cycle

    localparam int SEC_PER_MIN  = 60;
    localparam int MIN_PER_HR   = 60;
    localparam int HR_PER_DAY   = 24;
    localparam int MON_PER_YR   = 12;
    localparam int YR_PER_CYCLE = 400;

    // reciprocal constants, rounded up; the rounding error of each is below
    // 2^(REC_SH-DIV_W), so the quotient is exact for any DIV_W-bit dividend
    localparam int REC_W    = 24;
    localparam int REC_SH   = 27;
    localparam int REC_SEC  = ((1 << REC_SH) + SEC_PER_MIN - 1) / SEC_PER_MIN;
    localparam int REC_MIN  = ((1 << REC_SH) + MIN_PER_HR - 1) / MIN_PER_HR;
    localparam int REC_HOUR = ((1 << REC_SH) + HR_PER_DAY - 1) / HR_PER_DAY;
    localparam int REC_MON  = ((1 << REC_SH) + MON_PER_YR - 1) / MON_PER_YR;
    localparam int REC_YEAR = ((1 << REC_SH) + YR_PER_CYCLE - 1) / YR_PER_CYCLE;

    // quotient offsets that keep every dividend non-negative
    localparam int OFS_SEC  = 1024;
    localparam int OFS_MIN  = 1024;
    localparam int OFS_HOUR = 2048;
    localparam int OFS_MON  = 16;
    localparam int OFS_YEAR = 1;

    localparam logic [MON_W-1:0] MON_JAN = 4'd1;
    localparam logic [MON_W-1:0] MON_FEB = 4'd2;
    localparam logic [MON_W-1:0] MON_APR = 4'd4;
    localparam logic [MON_W-1:0] MON_JUN = 4'd6;
    localparam logic [MON_W-1:0] MON_SEP = 4'd9;
    localparam logic [MON_W-1:0] MON_NOV = 4'd11;
    localparam logic [MON_W-1:0] MON_DEC = 4'd12;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_INIT   = 6'b000010,
        S_RUN    = 6'b000100,
        S_WB     = 6'b001000,
        S_WALK   = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    // division passes, in processing order
    typedef enum logic [2:0] {
        OP_SEC  = 3'd0,
        OP_MIN  = 3'd1,
        OP_HOUR = 3'd2,
        OP_MON  = 3'd3,
        OP_YEAR = 3'd4
    } t_op;

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic div_wb;
        logic walk_step;
        logic out_load;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic walk_done;
    } t_stat;

    function automatic logic [REM_W-1:0] f_divisor(input t_op op);
        logic [REM_W-1:0] d;
        unique case (op)
            OP_SEC:  d = REM_W'(SEC_PER_MIN);
            OP_MIN:  d = REM_W'(MIN_PER_HR);
            OP_HOUR: d = REM_W'(HR_PER_DAY);
            OP_MON:  d = REM_W'(MON_PER_YR);
            OP_YEAR: d = REM_W'(YR_PER_CYCLE);
            default: d = REM_W'(YR_PER_CYCLE);
        endcase
        return d;
    endfunction

    function automatic logic [REC_W-1:0] f_recip(input t_op op);
        logic [REC_W-1:0] m;
        unique case (op)
            OP_SEC:  m = REC_W'(REC_SEC);
            OP_MIN:  m = REC_W'(REC_MIN);
            OP_HOUR: m = REC_W'(REC_HOUR);
            OP_MON:  m = REC_W'(REC_MON);
            OP_YEAR: m = REC_W'(REC_YEAR);
            default: m = REC_W'(REC_YEAR);
        endcase
        return m;
    endfunction

    function automatic logic signed [SUM_W-1:0] f_offset(input t_op op);
        logic signed [SUM_W-1:0] k;
        unique case (op)
            OP_SEC:  k = SUM_W'(OFS_SEC);
            OP_MIN:  k = SUM_W'(OFS_MIN);
            OP_HOUR: k = SUM_W'(OFS_HOUR);
            OP_MON:  k = SUM_W'(OFS_MON);
            OP_YEAR: k = SUM_W'(OFS_YEAR);
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic logic signed [SUM_W-1:0] f_bias(input t_op op);
        logic signed [SUM_W-1:0] b;
        unique case (op)
            OP_SEC:  b = SUM_W'(OFS_SEC * SEC_PER_MIN);
            OP_MIN:  b = SUM_W'(OFS_MIN * MIN_PER_HR);
            OP_HOUR: b = SUM_W'(OFS_HOUR * HR_PER_DAY);
            OP_MON:  b = SUM_W'(OFS_MON * MON_PER_YR);
            OP_YEAR: b = SUM_W'(OFS_YEAR * YR_PER_CYCLE);
            default: b = '0;
        endcase
        return b;
    endfunction

    // leap test on the year's place within the 400 year cycle
    function automatic logic f_leap(input logic [CYC_W-1:0] cyc);
        logic century;
        century = (cyc == CYC_W'(0)) || (cyc == CYC_W'(100)) ||
                  (cyc == CYC_W'(200)) || (cyc == CYC_W'(300));
        return ((cyc[1:0] == 2'b00) && !century) || (cyc == CYC_W'(0));
    endfunction

    function automatic logic [DAY_W-1:0] f_month_days(input logic [MON_W-1:0] mon,
                                                      input logic leap);
        logic [DAY_W-1:0] n;
        case (mon) inside
            MON_FEB:                           n = leap ? 5'd29 : 5'd28;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: n = 5'd30;
            default:                           n = 5'd31;
        endcase
        return n;
    endfunction

endpackage

// File: rtl/dtn_ctrl.sv
`timescale 1ns / 1ps

module dtn_ctrl
    import dtn_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state           r_state, n_state;
    t_op              r_op, n_op;
    logic             r_out_valid, n_out_valid;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_SEC;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

    // sequencing: five division passes, then the month walk
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        o_cmd   = '0;
        o_cmd.op = r_op;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_op       = OP_SEC;
                    n_state    = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_RUN;
            end
            S_RUN: begin
                o_cmd.div_step = 1'b1;
                n_state        = S_WB;
            end
            S_WB: begin
                o_cmd.div_wb = 1'b1;
                unique case (r_op)
                    OP_SEC:  begin n_op = OP_MIN;  n_state = S_INIT; end
                    OP_MIN:  begin n_op = OP_HOUR; n_state = S_INIT; end
                    OP_HOUR: begin n_op = OP_MON;  n_state = S_INIT; end
                    OP_MON:  begin n_op = OP_YEAR; n_state = S_INIT; end
                    default: n_state = S_WALK;
                endcase
            end
            S_WALK: begin
                if (i_stat.walk_done) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output beat holds until taken
    always_comb begin
        n_out_valid = o_cmd.out_load | (r_out_valid & i_out_stall);
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/dtn_datapath.sv
`timescale 1ns / 1ps

module dtn_datapath
    import dtn_pkg::*;
(
    input  logic                       i_clk,
    input  t_cmd                       i_cmd,
    output t_stat                      o_stat,
    input  logic        [YR_IN_W-1:0]  i_in_year,
    input  logic signed [MON_IN_W-1:0] i_in_month,
    input  logic signed [FLD_IN_W-1:0] i_in_day,
    input  logic signed [FLD_IN_W-1:0] i_in_hour,
    input  logic signed [FLD_IN_W-1:0] i_in_minute,
    input  logic signed [FLD_IN_W-1:0] i_in_second,
    output logic signed [YR_OUT_W-1:0] o_out_year,
    output logic        [MON_W-1:0]    o_out_month,
    output logic        [DAY_W-1:0]    o_out_day,
    output logic        [HR_W-1:0]     o_out_hour,
    output logic        [MIN_W-1:0]    o_out_minute,
    output logic        [SEC_W-1:0]    o_out_second
);

    // working values
    logic signed [VAL_W-1:0]    r_sc, r_mn, r_hr, r_dy;
    logic signed [MON_IN_W-1:0] r_mon_raw;
    logic        [MON_W-1:0]    r_mon;
    logic signed [YR_W-1:0]     r_yr;
    logic        [CYC_W-1:0]    r_cyc;

    // divider
    logic [DIV_W-1:0] r_num;
    logic [DIV_W-1:0] r_quo;

    logic signed [VAL_W-1:0]       div_val;
    logic signed [SUM_W-1:0]       div_sum;
    logic        [REM_W-1:0]       dvsr;
    logic        [REC_W-1:0]       recip;
    logic        [DIV_W+REC_W-1:0] prod;
    logic        [DIV_W-1:0]       quo_next;
    logic        [DIV_W+REM_W-1:0] back;
    logic        [DIV_W-1:0]       rem_full;
    logic        [REM_W-1:0]       rem;
    logic signed [SUM_W-1:0]       quo_adj;
    logic signed [VAL_W-1:0]       quo_s;
    logic signed [VAL_W-1:0]       rem_s;

    // walk
    logic                    leap_cur, leap_prev;
    logic [CYC_W-1:0]        cyc_next, cyc_prev;
    logic [MON_W-1:0]        mon_prev;
    logic [DAY_W-1:0]        mlen_cur, mlen_prev;
    logic signed [VAL_W-1:0] mlen_cur_s, mlen_prev_s;
    logic                    dy_pos;

    // dividend selection, offset so the unsigned divide gives floor results
    always_comb begin
        unique case (i_cmd.op)
            OP_SEC:  div_val = r_sc;
            OP_MIN:  div_val = r_mn;
            OP_HOUR: div_val = r_hr;
            OP_MON:  div_val = VAL_W'(r_mon_raw) - VAL_W'(1);
            OP_YEAR: div_val = VAL_W'(r_yr);
            default: div_val = '0;
        endcase
        div_sum = SUM_W'(div_val) + f_bias(i_cmd.op);
        dvsr    = f_divisor(i_cmd.op);
        recip   = f_recip(i_cmd.op);
    end

    // quotient by reciprocal multiply, remainder by multiply back
    always_comb begin
        prod     = {{REC_W{1'b0}}, r_num} * {{DIV_W{1'b0}}, recip};
        quo_next = DIV_W'(prod[DIV_W+REC_W-1:REC_SH]);
        back     = {{REM_W{1'b0}}, r_quo} * {{DIV_W{1'b0}}, dvsr};
        rem_full = r_num - back[DIV_W-1:0];
        rem      = rem_full[REM_W-1:0];
    end

    // quotient with offset removed, remainder widened
    always_comb begin
        quo_adj = $signed({1'b0, r_quo}) - f_offset(i_cmd.op);
        quo_s   = quo_adj[VAL_W-1:0];
        rem_s   = $signed({{(VAL_W-REM_W){1'b0}}, rem});
    end

    // month lengths around the current position
    always_comb begin
        leap_cur  = f_leap(r_cyc);
        mlen_cur  = f_month_days(r_mon, leap_cur);
        cyc_next  = (r_cyc == CYC_W'(YR_PER_CYCLE - 1)) ? '0 : r_cyc + CYC_W'(1);
        cyc_prev  = (r_cyc == '0) ? CYC_W'(YR_PER_CYCLE - 1) : r_cyc - CYC_W'(1);
        if (r_mon == MON_JAN) begin
            mon_prev  = MON_DEC;
            leap_prev = f_leap(cyc_prev);
        end else begin
            mon_prev  = r_mon - MON_W'(1);
            leap_prev = leap_cur;
        end
        mlen_prev   = f_month_days(mon_prev, leap_prev);
        mlen_cur_s  = $signed({{(VAL_W-DAY_W){1'b0}}, mlen_cur});
        mlen_prev_s = $signed({{(VAL_W-DAY_W){1'b0}}, mlen_prev});
        dy_pos      = (r_dy > VAL_W'(0));
        o_stat.walk_done = dy_pos && (r_dy <= mlen_cur_s);
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_yr      <= $signed({{(YR_W-YR_IN_W){1'b0}}, i_in_year});
            r_mon_raw <= i_in_month;
            r_dy      <= VAL_W'(i_in_day);
            r_hr      <= VAL_W'(i_in_hour);
            r_mn      <= VAL_W'(i_in_minute);
            r_sc      <= VAL_W'(i_in_second);
        end
        if (i_cmd.div_init) begin
            r_num <= div_sum[DIV_W-1:0];
        end
        if (i_cmd.div_step) begin
            r_quo <= quo_next;
        end
        if (i_cmd.div_wb) begin
            unique case (i_cmd.op)
                OP_SEC: begin
                    r_mn <= r_mn + quo_s;
                    r_sc <= rem_s;
                end
                OP_MIN: begin
                    r_hr <= r_hr + quo_s;
                    r_mn <= rem_s;
                end
                OP_HOUR: begin
                    r_dy <= r_dy + quo_s;
                    r_hr <= rem_s;
                end
                OP_MON: begin
                    r_yr  <= r_yr + quo_s[YR_W-1:0];
                    r_mon <= rem[MON_W-1:0] + MON_W'(1);
                end
                OP_YEAR: begin
                    r_cyc <= rem;
                end
                default: begin
                    r_cyc <= r_cyc;
                end
            endcase
        end
        // one month crossed per cycle
        if (i_cmd.walk_step) begin
            if (dy_pos) begin
                r_dy <= r_dy - mlen_cur_s;
                if (r_mon == MON_DEC) begin
                    r_mon <= MON_JAN;
                    r_yr  <= r_yr + YR_W'(1);
                    r_cyc <= cyc_next;
                end else begin
                    r_mon <= r_mon + MON_W'(1);
                end
            end else begin
                r_dy  <= r_dy + mlen_prev_s;
                r_mon <= mon_prev;
                if (r_mon == MON_JAN) begin
                    r_yr  <= r_yr - YR_W'(1);
                    r_cyc <= cyc_prev;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_year   <= r_yr[YR_OUT_W-1:0];
            o_out_month  <= r_mon;
            o_out_day    <= r_dy[DAY_W-1:0];
            o_out_hour   <= r_hr[HR_W-1:0];
            o_out_minute <= r_mn[MIN_W-1:0];
            o_out_second <= r_sc[SEC_W-1:0];
        end
    end

endmodule

// File: rtl/date_time_normalizer_top.sv
`timescale 1ns / 1ps

// Gregorian date and time normalizer. One date and time beat in, one
// normalized beat out. Seconds, minutes, hours and the month are reduced
// by floor division on a shared reciprocal-multiply divider (five passes,
// the last giving the year's place in the 400 year cycle), then the day is
// walked across months one month per cycle with February at 29 days in leap
// years. The input is free again after the result is loaded. One item is in
// work at a time; a finished result waits in the output register while the
// next item is taken. Years that leave the 15-bit output wrap in two's
// complement.
module date_time_normalizer_top
    import dtn_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic        [YR_IN_W-1:0]  i_in_year,
    input  logic signed [MON_IN_W-1:0] i_in_month,
    input  logic signed [FLD_IN_W-1:0] i_in_day,
    input  logic signed [FLD_IN_W-1:0] i_in_hour,
    input  logic signed [FLD_IN_W-1:0] i_in_minute,
    input  logic signed [FLD_IN_W-1:0] i_in_second,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [YR_OUT_W-1:0] o_out_year,
    output logic        [MON_W-1:0]    o_out_month,
    output logic        [DAY_W-1:0]    o_out_day,
    output logic        [HR_W-1:0]     o_out_hour,
    output logic        [MIN_W-1:0]    o_out_minute,
    output logic        [SEC_W-1:0]    o_out_second
);

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    dtn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // arithmetic and result register
    dtn_datapath u_dp (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_in_year    (i_in_year),
        .i_in_month   (i_in_month),
        .i_in_day     (i_in_day),
        .i_in_hour    (i_in_hour),
        .i_in_minute  (i_in_minute),
        .i_in_second  (i_in_second),
        .o_out_year   (o_out_year),
        .o_out_month  (o_out_month),
        .o_out_day    (o_out_day),
        .o_out_hour   (o_out_hour),
        .o_out_minute (o_out_minute),
        .o_out_second (o_out_second)
    );

endmodule

// File: rtl/dtn_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dtn_checker
    import dtn_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic signed [YR_OUT_W-1:0] o_out_year,
    input logic        [MON_W-1:0]    o_out_month,
    input logic        [DAY_W-1:0]    o_out_day,
    input logic        [HR_W-1:0]     o_out_hour,
    input logic        [MIN_W-1:0]    o_out_minute,
    input logic        [SEC_W-1:0]    o_out_second
);

    // a stalled output beat keeps its contents
    `DTN_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_year) && $stable(o_out_month) && $stable(o_out_day) && $stable(o_out_hour) && $stable(o_out_minute) && $stable(o_out_second))

    // an accepted beat keeps the input side busy while it is worked on
    `DTN_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // a delivered beat has month, hour, minute and second in range and a day of at least 1
    `DTN_ASSERT_NOW(a_out_range, i_clk, i_rst_n, o_out_valid, o_out_month >= 4'd1 && o_out_month <= 4'd12 && o_out_day >= 5'd1 && o_out_hour < 5'd24 && o_out_minute < 6'd60 && o_out_second < 6'd60)

    // day does not exceed 29 in February or 30 in the 30-day months
    `DTN_ASSERT_NOW(a_feb_days, i_clk, i_rst_n, o_out_valid && o_out_month == MON_FEB, o_out_day <= 5'd29)
    `DTN_ASSERT_NOW(a_short_month_days, i_clk, i_rst_n, o_out_valid && (o_out_month == MON_APR || o_out_month == MON_JUN || o_out_month == MON_SEP || o_out_month == MON_NOV), o_out_day <= 5'd30)

endmodule

bind date_time_normalizer_top dtn_checker u_dtn_checker (.*);
